/* sv/bfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types, constants and tables of the first-digit conformity test.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int COUNT_BITS = 32;
  localparam logic [COUNT_BITS-1:0] COUNT_CAP = '1;

  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // shared iterative units
  localparam int MUL_A_W = 104;
  localparam int MUL_B_W = 52;
  localparam int MUL_P_W = MUL_A_W + 14;
  localparam int DIV_N_W = 104;
  localparam int DIV_D_W = 64;

  localparam logic [39:0] CHI_MAX = '1;
  localparam logic [51:0] Z_SCALE = 52'd15625;

  // MAD = floor((sum + 72) / 144): drop four bits, then multiply by ceil(2^24/9)
  // and keep bits 24 and up; exact for a shifted sum below 2^21
  localparam logic [24:0] MAD_RND   = 25'd72;
  localparam logic [20:0] MAD_RECIP = 21'd1864136;

  localparam logic [1:0] CONF_CLOSE      = 2'd0;
  localparam logic [1:0] CONF_ACCEPTABLE = 2'd1;
  localparam logic [1:0] CONF_MARGINAL   = 2'd2;
  localparam logic [1:0] CONF_NONCONFORM = 2'd3;

  localparam logic [1:0] REG_CLOSE      = 2'd0;
  localparam logic [1:0] REG_ACCEPTABLE = 2'd1;
  localparam logic [1:0] REG_MARGINAL   = 2'd2;

  // Benford proportions, Q0.20
  localparam logic [19:0] P_Q20 [9] = '{
    20'd315653, 20'd184645, 20'd131008, 20'd101618, 20'd83028,
    20'd70199, 20'd60809, 20'd53637, 20'd47980
  };

  // z-test right side constant: p*(2^20-p)*103684
  localparam logic [54:0] Z_K [9] = '{
    55'(64'd315653 * 64'd732923 * 64'd103684),
    55'(64'd184645 * 64'd863931 * 64'd103684),
    55'(64'd131008 * 64'd917568 * 64'd103684),
    55'(64'd101618 * 64'd946958 * 64'd103684),
    55'(64'd83028 * 64'd965548 * 64'd103684),
    55'(64'd70199 * 64'd978377 * 64'd103684),
    55'(64'd60809 * 64'd987767 * 64'd103684),
    55'(64'd53637 * 64'd994939 * 64'd103684),
    55'(64'd47980 * 64'd1000596 * 64'd103684)
  };

  localparam logic [67:0] P10 [20] = '{
    68'd1, 68'd10, 68'd100, 68'd1000, 68'd10000, 68'd100000, 68'd1000000,
    68'd10000000, 68'd100000000, 68'd1000000000, 68'd10000000000,
    68'd100000000000, 68'd1000000000000, 68'd10000000000000,
    68'd100000000000000, 68'd1000000000000000, 68'd10000000000000000,
    68'd100000000000000000, 68'd1000000000000000000,
    68'd10000000000000000000
  };

  typedef struct packed {
    logic       kind;
    logic       keep;
    logic [3:0] idx;
  } q_item_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [Q_CNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic [15:0] close_lim;
    logic [15:0] accept_lim;
    logic [15:0] marg_lim;
  } limits_t;

endpackage
`default_nettype wire

/* sv/benford_first_digit_test_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// benford_first_digit_test_unit
// Leading-digit histogram with a Benford conformity test on finish.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word per item. kind 0 is a value:
//   its leading decimal digit is counted unless it is flagged not finite or
//   its integer part is zero. kind 1 is a finish: one result word follows.
// Value words are taken one per cycle unless in_stall holds them. A classifier
// (two register stages) feeds an eight-word queue; the statistics engine drains
// it one word per cycle, so in_stall rises only behind a finish being worked
// off or waiting. A finish reaches the engine through the classifier and the
// queue, then runs per digit two setup steps, three multiplies on the shift-add
// multiplier and two divides on the restoring divider, then the MAD by
// reciprocal multiply. An empty finish gives an all-zero result word once it
// reaches the engine.
// Output channel (out_valid / out_stall): the result word sits in an output
// register; value words keep being counted while it waits. A further finish
// waits in the queue until the word is taken.
// Config port: cfg_valid / cfg_ready, always ready; index 0..2 selects the
// close, acceptable and marginal MAD limits, other indexes are dropped.
// Reset (rst, synchronous) clears the histogram, queue and result, and loads
// the limits 393, 786, 983.
// ----------------------------------------------------------------------------
module benford_first_digit_test_unit import bfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [63:0] sample,
  input  wire logic        not_finite,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      valid_count,
  output logic [39:0]      chi_stat,
  output logic [15:0]      mean_abs_dev,
  output logic [8:0]       digit_flags,
  output logic             suspicious,
  output logic [1:0]       conformity,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  limits_t lim;
  q_item_t f_item, q_item;
  q_stat_t q_stat;
  logic    take, f_push, f_b1, f_b2, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lim.close_lim  <= 16'd393;
      lim.accept_lim <= 16'd786;
      lim.marg_lim   <= 16'd983;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CLOSE:      lim.close_lim  <= cfg_data;
        REG_ACCEPTABLE: lim.accept_lim <= cfg_data;
        REG_MARGINAL:   lim.marg_lim   <= cfg_data;
        default: ;
      endcase
    end
  end

  // credit: queue plus words in flight in the classifier must fit
  assign in_stall = (q_stat.count + Q_CNT_W'(f_b1) + Q_CNT_W'(f_b2)) >=
                    Q_CNT_W'(Q_DEPTH);
  assign take = in_valid && !in_stall;

  bfd_front u_front (
    .clk(clk), .rst(rst), .take(take), .kind(kind), .sample(sample),
    .not_finite(not_finite), .busy1(f_b1), .busy2(f_b2), .push(f_push),
    .item(f_item)
  );

  bfd_fifo u_fifo (
    .clk(clk), .rst(rst), .push(f_push), .din(f_item), .pop(q_pop),
    .dout(q_item), .stat(q_stat)
  );

  bfd_back u_back (
    .clk(clk), .rst(rst), .item(q_item), .qstat(q_stat), .pop(q_pop),
    .lim(lim), .out_stall(out_stall), .out_valid(out_valid),
    .valid_count(valid_count), .chi_stat(chi_stat),
    .mean_abs_dev(mean_abs_dev), .digit_flags(digit_flags),
    .suspicious(suspicious), .conformity(conformity)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_push |-> !q_stat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_susp_mad: assert property (@(posedge clk) disable iff (rst)
    (out_valid && suspicious) |-> (mean_abs_dev != 16'd0))
    else $error("suspicious flag with zero deviation");

endmodule
`default_nettype wire

/* sv/bfd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_front
// Two-stage classifier: magnitude, decade search, leading digit.
// ----------------------------------------------------------------------------
module bfd_front import bfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic        kind,
  input  wire logic [63:0] sample,
  input  wire logic        not_finite,
  output logic             busy1,
  output logic             busy2,
  output logic             push,
  output q_item_t          item
);

  logic        s1_v, s1_kind, s1_keep;
  logic [63:0] s1_mag;
  logic [4:0]  s1_k;
  logic [63:0] mag;
  logic [4:0]  k;
  logic [3:0]  idx;
  logic [67:0] pk;

  always_comb begin
    mag = sample[63] ? (64'd0 - sample) : sample;
    k = '0;
    for (int i = 1; i < 20; i++) begin
      if ({4'd0, mag} >= P10[i]) k = 5'(i);
    end
  end

  always_comb begin
    pk = P10[s1_k];
    idx = '0;
    for (int j = 2; j < 10; j++) begin
      if ({4'd0, s1_mag} >= pk * 68'(j)) idx = 4'(j - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      push <= 1'b0;
    end else begin
      s1_v <= take;
      push <= s1_v;
    end
    if (take) begin
      s1_kind <= kind;
      s1_keep <= !not_finite && (mag != 64'd0);
      s1_mag  <= mag;
      s1_k    <= k;
    end
    if (s1_v) begin
      item.kind <= s1_kind;
      item.keep <= s1_keep;
      item.idx  <= idx;
    end
  end

  assign busy1 = s1_v;
  assign busy2 = push;

endmodule
`default_nettype wire

/* sv/bfd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_fifo
// Short queue between classifier and statistics engine.
// ----------------------------------------------------------------------------
module bfd_fifo import bfd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire q_item_t din,
  input  wire logic    pop,
  output q_item_t      dout,
  output q_stat_t      stat
);

  q_item_t            mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp, rp;
  logic [Q_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      count <= count + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
    if (push) mem[wp] <= din;
  end

  assign dout = mem[rp];
  assign stat.count = count;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == Q_CNT_W'(Q_DEPTH));

endmodule
`default_nettype wire

/* sv/bfd_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module bfd_mul import bfd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic [MUL_P_W-1:0]      p
);

  localparam int CW = $clog2(MUL_B_W);

  logic [MUL_P_W-1:0] ash;
  logic [MUL_B_W-1:0] bsh;
  logic [CW-1:0]      cnt;
  logic               run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CW'(MUL_B_W - 1));
      if (start) run <= 1'b1;
      else if (cnt == CW'(MUL_B_W - 1)) run <= 1'b0;
    end
    if (start) begin
      p   <= '0;
      ash <= MUL_P_W'(a);
      bsh <= b;
      cnt <= '0;
    end else if (run) begin
      if (bsh[0]) p <= p + ash;
      ash <= ash << 1;
      bsh <= bsh >> 1;
      cnt <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

/* sv/bfd_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfd_div import bfd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DIV_N_W-1:0] num,
  input  wire logic [DIV_D_W-1:0] den,
  output logic                    done,
  output logic [DIV_N_W-1:0]      q
);

  localparam int CW = $clog2(DIV_N_W);

  logic [DIV_N_W-1:0] nsh;
  logic [DIV_D_W-1:0] rem, dsh;
  logic [DIV_D_W:0]   rt;
  logic               ge;
  logic [CW-1:0]      cnt;
  logic               run;

  assign rt = {rem, nsh[DIV_N_W-1]};
  assign ge = (rt >= {1'b0, dsh});

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CW'(DIV_N_W - 1));
      if (start) run <= 1'b1;
      else if (cnt == CW'(DIV_N_W - 1)) run <= 1'b0;
    end
    if (start) begin
      nsh <= num;
      dsh <= den;
      rem <= '0;
      q   <= '0;
      cnt <= '0;
    end else if (run) begin
      rem <= ge ? DIV_D_W'(rt - {1'b0, dsh}) : DIV_D_W'(rt);
      q   <= {q[DIV_N_W-2:0], ge};
      nsh <= nsh << 1;
      cnt <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

/* sv/bfd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_back
// Histogram and finish sequencer: per digit runs the products and quotients
// on the shared multiplier and divider, then the MAD and conformity level.
// ----------------------------------------------------------------------------
module bfd_back import bfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire q_item_t     item,
  input  wire q_stat_t     qstat,
  output logic             pop,
  input  wire limits_t     lim,
  input  wire logic        out_stall,
  output logic             out_valid,
  output logic [31:0]      valid_count,
  output logic [39:0]      chi_stat,
  output logic [15:0]      mean_abs_dev,
  output logic [8:0]       digit_flags,
  output logic             suspicious,
  output logic [1:0]       conformity
);

  typedef enum logic [6:0] {
    ST_COUNT = 7'b0000001,
    ST_PROD  = 7'b0000010,
    ST_DEV   = 7'b0000100,
    ST_OP    = 7'b0001000,
    ST_WAIT  = 7'b0010000,
    ST_MAD   = 7'b0100000,
    ST_MADW  = 7'b1000000
  } state_t;

  typedef enum logic [2:0] {
    OP_SQ   = 3'd0,
    OP_LHS  = 3'd1,
    OP_RHS  = 3'd2,
    OP_ADEV = 3'd3,
    OP_CHI  = 3'd4
  } op_t;

  state_t state;
  op_t    op;

  logic [COUNT_BITS-1:0] counts [9];
  logic [COUNT_BITS-1:0] total;
  logic [3:0]            digit;
  logic [51:0]           xr, yr, dv;
  logic [103:0]          sq;
  logic [MUL_P_W-1:0]    lhs;
  logic [59:0]           dev_sum;
  logic [39:0]           chi;
  logic                  chi_sat;
  logic [8:0]            flags;
  logic [15:0]           mad;
  logic [40:0]           chi_add;
  logic [24:0]           mad_sum;
  logic [20:0]           mad_y;
  logic [41:0]           mad_prod;

  logic               mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [DIV_N_W-1:0] div_n, div_q;
  logic [DIV_D_W-1:0] div_d;

  bfd_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  bfd_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .q(div_q)
  );

  // finish items wait until the previous result has been taken
  assign pop = (state == ST_COUNT) && !qstat.empty && (!item.kind || !out_valid);

  always_comb begin
    mul_a = MUL_A_W'(dv);
    mul_b = MUL_B_W'(dv);
    div_n = DIV_N_W'(dv);
    div_d = DIV_D_W'(total);
    case (op)
      OP_LHS: begin
        mul_a = sq;
        mul_b = Z_SCALE;
      end
      OP_RHS: begin
        mul_a = MUL_A_W'(Z_K[digit]);
        mul_b = MUL_B_W'(total);
      end
      OP_CHI: begin
        div_n = sq;
        div_d = DIV_D_W'({yr, 12'd0});
      end
      default: ;
    endcase
    mul_start = (state == ST_OP) && (op == OP_SQ || op == OP_LHS || op == OP_RHS);
    div_start = (state == ST_OP) && (op == OP_ADEV || op == OP_CHI);
    chi_add = {1'b0, chi} + {1'b0, div_q[39:0]};
    // deviation sum stays below 9*2^20, so 25 bits hold it with the rounding
    mad_sum  = 25'(dev_sum) + MAD_RND;
    mad_y    = mad_sum[24:4];
    mad_prod = {21'd0, mad_y} * {21'd0, MAD_RECIP};
    mad = (mad_prod[41:40] != 2'b00) ? 16'hFFFF : mad_prod[39:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COUNT;
      op <= OP_SQ;
      out_valid <= 1'b0;
      total <= '0;
      for (int i = 0; i < 9; i++) counts[i] <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ST_COUNT: begin
          if (pop) begin
            if (!item.kind) begin
              if (item.keep && total != COUNT_CAP) begin
                total <= total + 1'b1;
                for (int i = 0; i < 9; i++) begin
                  if (item.idx == 4'(i)) counts[i] <= counts[i] + 1'b1;
                end
              end
            end else if (total == '0) begin
              out_valid    <= 1'b1;
              valid_count  <= '0;
              chi_stat     <= '0;
              mean_abs_dev <= '0;
              digit_flags  <= '0;
              suspicious   <= 1'b0;
              conformity   <= CONF_CLOSE;
            end else begin
              digit   <= '0;
              dev_sum <= '0;
              chi     <= '0;
              chi_sat <= 1'b0;
              flags   <= '0;
              state   <= ST_PROD;
            end
          end
        end
        ST_PROD: begin
          yr <= 52'(P_Q20[digit] * total);
          xr <= {counts[digit], 20'd0};
          state <= ST_DEV;
        end
        ST_DEV: begin
          dv <= (xr >= yr) ? xr - yr : yr - xr;
          op <= OP_SQ;
          state <= ST_OP;
        end
        ST_OP: state <= ST_WAIT;
        ST_WAIT: begin
          if (mul_done || div_done) begin
            state <= ST_OP;
            case (op)
              OP_SQ:  begin sq <= 104'(mul_p); op <= OP_LHS; end
              OP_LHS: begin lhs <= mul_p; op <= OP_RHS; end
              OP_RHS: begin
                flags[digit] <= lhs > mul_p;
                op <= OP_ADEV;
              end
              OP_ADEV: begin
                dev_sum <= dev_sum + 60'(div_q[51:0]);
                op <= OP_CHI;
              end
              OP_CHI: begin
                if (div_q > DIV_N_W'(CHI_MAX) || chi_add[40]) chi_sat <= 1'b1;
                else chi <= chi_add[39:0];
                op <= OP_SQ;
                if (digit == 4'd8) state <= ST_MAD;
                else begin
                  digit <= digit + 1'b1;
                  state <= ST_PROD;
                end
              end
              default: op <= OP_SQ;
            endcase
          end
        end
        ST_MAD: state <= ST_MADW;
        ST_MADW: begin
          out_valid    <= 1'b1;
          valid_count  <= 32'(total);
          chi_stat     <= chi_sat ? CHI_MAX : chi;
          mean_abs_dev <= mad;
          digit_flags  <= flags;
          suspicious   <= mad > lim.marg_lim;
          if (mad <= lim.close_lim) conformity <= CONF_CLOSE;
          else if (mad <= lim.accept_lim) conformity <= CONF_ACCEPTABLE;
          else if (mad <= lim.marg_lim) conformity <= CONF_MARGINAL;
          else conformity <= CONF_NONCONFORM;
          total <= '0;
          for (int i = 0; i < 9; i++) counts[i] <= '0;
          state <= ST_COUNT;
        end
        default: state <= ST_COUNT;
      endcase
    end
  end

endmodule
`default_nettype wire

/* verif/benford_first_digit_test_checker.sv */
// ----------------------------------------------------------------------------
// benford_first_digit_test_checker
// Watches the data and config channels and keeps its own leading-digit
// histogram. It predicts the statistics word of every finish and compares
// each accepted result word field by field.
// ----------------------------------------------------------------------------
module benford_first_digit_test_checker import bfd_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        kind,
  input  wire logic [63:0] sample,
  input  wire logic        not_finite,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] valid_count,
  input  wire logic [39:0] chi_stat,
  input  wire logic [15:0] mean_abs_dev,
  input  wire logic [8:0]  digit_flags,
  input  wire logic        suspicious,
  input  wire logic [1:0]  conformity,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);

  typedef struct packed {
    logic [31:0] cnt;
    logic [39:0] chi;
    logic [15:0] mad;
    logic [8:0]  flags;
    logic        susp;
    logic [1:0]  conf;
  } stats_t;

  // Benford shares log10(1+1/d), Q0.20
  localparam logic [19:0] DIGIT_SHARE [9] = '{
    20'd315653, 20'd184645, 20'd131008, 20'd101618, 20'd83028,
    20'd70199, 20'd60809, 20'd53637, 20'd47980
  };

  logic [31:0] hist [9];
  logic [31:0] total;
  logic [15:0] lim_close, lim_accept, lim_marg;
  stats_t      expected_stats [$];

  function automatic stats_t benford_stats();
    stats_t       r;
    logic [127:0] x, y, dv, q, chi_acc, lhs, rhs;
    logic [63:0]  dev_sum, mad_w;
    logic         chi_sat;
    r = '0;
    chi_acc = '0;
    dev_sum = '0;
    chi_sat = 1'b0;
    if (total == 0) return r;
    for (int d = 0; d < 9; d++) begin
      x = 128'(hist[d]) << 20;
      y = 128'(DIGIT_SHARE[d]) * 128'(total);
      dv = (x >= y) ? x - y : y - x;
      dev_sum += 64'(dv / 128'(total));
      if (dv >= (128'd1 << 60)) chi_sat = 1'b1;
      else if (!chi_sat) begin
        q = (dv * dv) / (y << 12);
        chi_acc += q;
        if (chi_acc > 128'(CHI_MAX)) chi_sat = 1'b1;
      end
      if (dv >= (128'd1 << 56)) r.flags[d] = 1'b1;
      else begin
        lhs = dv * dv * 128'd15625;
        rhs = 128'(DIGIT_SHARE[d]) * (128'd1048576 - 128'(DIGIT_SHARE[d]))
              * 128'd103684 * 128'(total);
        if (lhs > rhs) r.flags[d] = 1'b1;
      end
    end
    mad_w = (dev_sum + 64'd72) / 64'd144;
    if (mad_w > 64'hFFFF) mad_w = 64'hFFFF;
    r.cnt = total;
    r.chi = chi_sat ? CHI_MAX : chi_acc[39:0];
    r.mad = mad_w[15:0];
    r.susp = (r.mad > lim_marg);
    if (r.mad <= lim_close) r.conf = CONF_CLOSE;
    else if (r.mad <= lim_accept) r.conf = CONF_ACCEPTABLE;
    else if (r.mad <= lim_marg) r.conf = CONF_MARGINAL;
    else r.conf = CONF_NONCONFORM;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    logic [63:0] mag;
    stats_t      e;
    if (rst) begin
      for (int d = 0; d < 9; d++) hist[d] = '0;
      total = '0;
      lim_close = 16'd393;
      lim_accept = 16'd786;
      lim_marg = 16'd983;
      expected_stats.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CLOSE:      lim_close = cfg_data;
          REG_ACCEPTABLE: lim_accept = cfg_data;
          REG_MARGINAL:   lim_marg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (kind) begin
          expected_stats.insert(expected_stats.size(), benford_stats());
          for (int d = 0; d < 9; d++) hist[d] = '0;
          total = '0;
        end else begin
          mag = sample[63] ? -sample : sample;
          if (!not_finite && mag != 0 && total != 32'hFFFF_FFFF) begin
            while (mag >= 10) mag = mag / 10;
            hist[4'(mag - 1)]++;
            total++;
          end
        end
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_stats.size() == 0) begin
          $display("%0t: result word with no expectation, expected none, actual count %0d",
                   $time, valid_count);
          fail_count++;
        end else begin
          e = expected_stats.pop_front();
          check_field("valid_count", e.cnt, valid_count);
          check_field("chi_stat", e.chi, chi_stat);
          check_field("mean_abs_dev", e.mad, mean_abs_dev);
          check_field("digit_flags", e.flags, digit_flags);
          check_field("suspicious", e.susp, suspicious);
          check_field("conformity", e.conf, conformity);
        end
      end
    end
    pending <= expected_stats.size();
  end

endmodule

/* verif/benford_first_digit_test_unit_tb.sv */
// ----------------------------------------------------------------------------
// benford_first_digit_test_unit_tb
// Drives value and finish words into the first-digit test unit, with random
// idling on both channels and several MAD limit settings; the checker beside
// the unit predicts and compares every statistics word.
// ----------------------------------------------------------------------------
module benford_first_digit_test_unit_tb;
  import bfd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;  // dropped by the unit
  localparam int WATCHDOG = 20000;           // outlasts a finish and the long hold
  localparam int LONG_HOLD = 5000;
  localparam int ITEM_GOAL = 1800;
  localparam int RESULT_GOAL = 48;
  localparam int unsigned DIGIT_W [9] = '{315653, 184645, 131008, 101618, 83028,
                                          70199, 60809, 53637, 47980};

  logic        clk;
  logic        rst;
  logic        in_valid, in_stall, kind, not_finite;
  logic [63:0] sample;
  logic        out_valid, out_stall;
  logic [31:0] valid_count;
  logic [39:0] chi_stat;
  logic [15:0] mean_abs_dev;
  logic [8:0]  digit_flags;
  logic        suspicious;
  logic [1:0]  conformity;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count, pending, results_seen;
  int words_sent, finishes_sent, cfg_writes;
  int idle_cycles;
  int rx_wait;
  bit tx_idle, rx_idle, hold_long;

  benford_first_digit_test_unit DUT (.*);

  benford_first_digit_test_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: any accepted word on either channel restarts the count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout: no word accepted for %0d cycles", WATCHDOG);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: stall count drawn after each taken word, counted down here;
  // a long hold request from the stimulus overrides it
  initial begin
    rx_wait = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        rx_wait = LONG_HOLD;
        hold_long = 1'b0;
      end else if (out_valid && !out_stall) begin
        rx_wait = rx_idle ? $urandom_range(0, 15) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0);
    end
  end

  // one word on the data channel; returns at the accepting edge
  task automatic put_word(logic k, logic [63:0] s, logic nf);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    sample <= s;
    not_finite <= nf;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (k) finishes_sent++;
  endtask

  // wait until every statistics word is out, plus slack for values in flight
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
  endtask

  task automatic set_limits(logic [15:0] c, logic [15:0] a, logic [15:0] m);
    write_limit(REG_CLOSE, c);
    write_limit(REG_ACCEPTABLE, a);
    write_limit(REG_MARGINAL, m);
    write_limit(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] pow10(int k);
    logic [63:0] p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  // value whose leading digit follows the Benford shares
  function automatic logic [63:0] benford_value();
    int unsigned r, acc, k;
    int d;
    logic [63:0] p;
    r = $urandom_range(0, 1048575);
    acc = 0;
    d = 9;
    for (int i = 0; i < 9; i++) begin
      acc += DIGIT_W[i];
      if (r < acc) begin
        d = i + 1;
        break;
      end
    end
    k = $urandom_range(0, 17);
    p = pow10(k);
    return 64'(d) * p + ({$urandom, $urandom} % p);
  endfunction

  // a random value word: mostly ordinary numbers, some zero, some full width
  task automatic random_value(bit benford);
    logic [63:0] v;
    logic        nf;
    nf = ($urandom_range(0, 11) == 0);
    case ($urandom_range(0, 9))
      0: v = {$urandom, $urandom};
      1: v = 64'd0;
      default: begin
        v = benford ? benford_value() : ({$urandom, $urandom} % pow10($urandom_range(1, 18)));
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    put_word(1'b0, v, nf);
  endtask

  // one data set closed by a finish; most are small, a few are large
  task automatic random_set();
    int  len;
    bit  benford;
    benford = $urandom_range(0, 2) != 0;
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = $urandom_range(100, 200);
      default: len = $urandom_range(1, 40);
    endcase
    repeat (len) random_value(benford);
    put_word(1'b1, {$urandom, $urandom}, 1'($urandom));
  endtask

  initial begin
    int phase;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = 1'b0;
    sample = '0;
    not_finite = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_long = 1'b0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    words_sent = 0;
    finishes_sent = 0;
    cfg_writes = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty finish first, with junk in the ignored fields
    put_word(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // field extremes and digit boundaries
    put_word(1'b0, 64'd1, 1'b0);
    put_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);  // -1
    put_word(1'b0, 64'd0, 1'b0);                    // zero integer part, skipped
    put_word(1'b0, 64'd9, 1'b0);
    put_word(1'b0, 64'd10, 1'b0);
    put_word(1'b0, 64'd99, 1'b0);
    put_word(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);  // most positive
    put_word(1'b0, 64'h8000_0000_0000_0000, 1'b0);  // most negative
    put_word(1'b0, 64'd123456, 1'b1);               // not finite, skipped
    put_word(1'b0, -64'd250, 1'b0);
    put_word(1'b0, 64'd19999, 1'b0);
    put_word(1'b1, 64'd0, 1'b0);
    // single-digit pile: large chi-square and flags
    repeat (6) put_word(1'b0, 64'd7, 1'b0);
    put_word(1'b1, 64'd5, 1'b0);
    // only skipped values before the finish: still empty
    put_word(1'b0, 64'd0, 1'b0);
    put_word(1'b0, 64'd42, 1'b1);
    put_word(1'b1, 64'd0, 1'b1);
    drain();

    phase = 0;
    while (words_sent < ITEM_GOAL || results_seen < RESULT_GOAL) begin
      // limits change only with nothing in flight
      case (phase % 6)
        0: set_limits(16'd393, 16'd786, 16'd983);
        1: set_limits(16'd0, 16'd0, 16'd0);
        2: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_limits(16'd900, 16'd300, 16'd600);   // unordered limits
        4: set_limits(16'd1000, 16'd3000, 16'd6000);
        default: set_limits(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 4000)),
                            16'($urandom_range(0, 8000)));
      endcase
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if (phase == 2) begin
        // receiver holds off while two finishes and plenty of values queue up
        hold_long = 1'b1;
        repeat (30) random_value(1'b1);
        put_word(1'b1, 64'd0, 1'b0);
        repeat (30) random_value(1'b1);
        put_word(1'b1, 64'd0, 1'b0);
        repeat (30) random_value(1'b1);
      end
      repeat (6) random_set();
      drain();   // sender pauses until every statistics word is back
      phase++;
    end

    $display("words sent %0d (finishes %0d), statistics words checked %0d",
             words_sent, finishes_sent, results_seen);
    $display("limit writes %0d over %0d limit settings", cfg_writes, phase);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
